// File: rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, command codes and command/status types of the PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_FRAC   = 24;
    localparam int INTEG_W   = 48;
    localparam int SUM_W     = INTEG_W + 2;
    localparam int MUL_W     = DATA_W + 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIV_SHIFT = DT_FRAC - FRAC_BITS;
    localparam int DVD_W     = 2 * DATA_W + DIV_SHIFT;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_AW    = 3;

    localparam logic [CFG_AW-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_FLOOR = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CEIL  = 3'd4;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CLAMP_LOW  = 2'd2;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_CLR    = 4'd1;
    localparam t_op OP_MKP    = 4'd2;
    localparam t_op OP_MKI    = 4'd3;
    localparam t_op OP_MLO    = 4'd4;
    localparam t_op OP_MHI    = 4'd5;
    localparam t_op OP_MKD    = 4'd6;
    localparam t_op OP_INT1   = 4'd7;
    localparam t_op OP_INT2   = 4'd8;
    localparam t_op OP_DIVI   = 4'd9;
    localparam t_op OP_DIV    = 4'd10;
    localparam t_op OP_DFIN   = 4'd11;
    localparam t_op OP_SUM    = 4'd12;
    localparam t_op OP_COMMIT = 4'd13;

    typedef struct packed {
        logic capture;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic clear_req;
        logic d_enable;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/pidaw_datapath.sv
// ----------------------------------------------------------------------------
// pidaw_datapath
// Gain registers, shared multiplier, two-bit-per-cycle divider, state and
// output registers of the PID block.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_datapath import pidaw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [DATA_W-1:0] i_cfg_wdata,
    input  wire logic              i_action,
    input  wire logic [DATA_W-1:0] i_error,
    input  wire logic [DATA_W-1:0] i_dt,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    output logic [DATA_W-1:0]      o_drive,
    output logic [1:0]             o_clamp
);

    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd, r_floor, r_ceil;
    logic r_action;
    logic signed [DATA_W-1:0] r_err;
    logic [DATA_W-1:0] r_dt;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [DATA_W-1:0] r_last;
    logic r_hist;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_kihi;
    logic [2*DATA_W-1:0] r_lo;
    logic signed [2*DATA_W:0] r_hi;
    logic signed [INTEG_W-1:0] r_p, r_inew, r_d;
    logic signed [INTEG_W+9:0] r_itrm;
    logic signed [2*DATA_W+1:0] r_num;
    logic [DVD_W-1:0] r_dvd, r_quo;
    logic [DATA_W-1:0] r_rem;
    logic signed [SUM_W-1:0] r_u;
    logic [DATA_W-1:0] r_drive;
    logic [1:0] r_clamp;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [DATA_W:0] diff;
    logic signed [2*DATA_W+1:0] itsum;
    logic signed [INTEG_W+10:0] isum;
    logic [2*DATA_W+1:0] nmag;
    logic [DATA_W:0] t0, t1;
    logic [DATA_W-1:0] rem0, rem1;
    logic q0, q1;
    logic big;
    logic signed [SUM_W-1:0] ceil_x, floor_x;

    localparam logic signed [INTEG_W+10:0] IMAX = (INTEG_W+11)'((64'sd1 <<< (INTEG_W-1)) - 1);
    localparam logic signed [INTEG_W+10:0] IMIN = -IMAX - 1;

    assign diff = DATA_W'(0) + (DATA_W+1)'(r_err) - (DATA_W+1)'(r_last);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MKP: begin
                mul_a = MUL_W'(r_kp);
                mul_b = MUL_W'(r_err);
            end
            OP_MKI: begin
                mul_a = MUL_W'(r_ki);
                mul_b = MUL_W'(r_err);
            end
            OP_MLO: begin
                mul_a = {2'b00, r_prod[DATA_W-1:0]};
                mul_b = {2'b00, r_dt};
            end
            OP_MHI: begin
                mul_a = MUL_W'(r_kihi);
                mul_b = {2'b00, r_dt};
            end
            OP_MKD: begin
                mul_a = MUL_W'(r_kd);
                mul_b = MUL_W'(diff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor((hi*2^32 + lo) / 2^40) only needs the upper word of lo
    assign itsum = (2*DATA_W+2)'(r_hi) + (2*DATA_W+2)'($signed({1'b0, r_lo[2*DATA_W-1:DATA_W]}));
    assign isum  = (INTEG_W+11)'(r_integ) + (INTEG_W+11)'(r_itrm);
    assign nmag  = r_num[2*DATA_W+1] ? (2*DATA_W+2)'(-r_num) : r_num;

    // two restoring steps per cycle
    assign t0   = {r_rem, r_dvd[DVD_W-1]};
    assign q0   = t0 >= {1'b0, r_dt};
    assign rem0 = q0 ? DATA_W'(t0 - {1'b0, r_dt}) : t0[DATA_W-1:0];
    assign t1   = {rem0, r_dvd[DVD_W-2]};
    assign q1   = t1 >= {1'b0, r_dt};
    assign rem1 = q1 ? DATA_W'(t1 - {1'b0, r_dt}) : t1[DATA_W-1:0];

    assign big = |r_quo[DVD_W-1:INTEG_W-1];

    assign ceil_x  = SUM_W'(r_ceil);
    assign floor_x = SUM_W'(r_floor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= DATA_W'(1) <<< FRAC_BITS;
            r_ki    <= '0;
            r_kd    <= '0;
            r_floor <= {1'b1, {(DATA_W-1){1'b0}}};
            r_ceil  <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_KP:    r_kp    <= i_cfg_wdata;
                CFG_KI:    r_ki    <= i_cfg_wdata;
                CFG_KD:    r_kd    <= i_cfg_wdata;
                CFG_FLOOR: r_floor <= i_cfg_wdata;
                CFG_CEIL:  r_ceil  <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    // controller state: integral, history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
            r_hist  <= 1'b0;
        end else if (i_cmd.op == OP_CLR) begin
            r_integ <= '0;
            r_last  <= '0;
            r_hist  <= 1'b0;
        end else if (i_cmd.op == OP_COMMIT) begin
            r_last <= r_err;
            r_hist <= 1'b1;
            if (r_u > ceil_x) begin
                if (r_err < 0) r_integ <= r_inew;
            end else if (r_u < floor_x) begin
                if (r_err > 0) r_integ <= r_inew;
            end else begin
                r_integ <= r_inew;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_err    <= i_error;
            r_dt     <= i_dt;
        end
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_MKI:  r_p    <= r_prod[FRAC_BITS +: INTEG_W];
            OP_MLO:  r_kihi <= r_prod[2*DATA_W-1:DATA_W];
            OP_MHI:  r_lo   <= r_prod[2*DATA_W-1:0];
            OP_MKD:  r_hi   <= r_prod[2*DATA_W:0];
            OP_INT1: begin
                r_itrm <= itsum[2*DATA_W+1:8];
                r_num  <= r_prod[2*DATA_W+1:0];
            end
            OP_INT2: begin
                if (isum > IMAX)      r_inew <= IMAX[INTEG_W-1:0];
                else if (isum < IMIN) r_inew <= IMIN[INTEG_W-1:0];
                else                  r_inew <= isum[INTEG_W-1:0];
            end
            OP_DIVI: begin
                r_dvd <= {nmag[2*DATA_W-1:0], {DIV_SHIFT{1'b0}}};
                r_quo <= '0;
                r_rem <= '0;
            end
            OP_DIV: begin
                r_dvd <= {r_dvd[DVD_W-3:0], 2'b00};
                r_quo <= {r_quo[DVD_W-3:0], q0, q1};
                r_rem <= rem1;
            end
            OP_DFIN: begin
                if (r_num < 0)
                    r_d <= big ? {1'b1, {(INTEG_W-1){1'b0}}} : -r_quo[INTEG_W-1:0];
                else
                    r_d <= big ? {1'b0, {(INTEG_W-1){1'b1}}} : r_quo[INTEG_W-1:0];
            end
            OP_SUM:  r_u <= SUM_W'(r_p) + SUM_W'(r_inew) + SUM_W'(r_d);
            OP_COMMIT: begin
                if (r_u > ceil_x) begin
                    r_drive <= r_ceil;
                    r_clamp <= CLAMP_HIGH;
                end else if (r_u < floor_x) begin
                    r_drive <= r_floor;
                    r_clamp <= CLAMP_LOW;
                end else begin
                    r_drive <= r_u[DATA_W-1:0];
                    r_clamp <= CLAMP_NONE;
                end
            end
            default: ;
        endcase
    end

    assign o_status.clear_req = r_action;
    assign o_status.d_enable  = (r_dt != '0) && r_hist;
    assign o_drive = r_drive;
    assign o_clamp = r_clamp;

endmodule

`default_nettype wire

// File: rtl/pidaw_controller.sv
// ----------------------------------------------------------------------------
// pidaw_controller
// Sequencer of the PID block: steps the datapath through one item and owns
// both stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_controller import pidaw_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_CLR  = 4'd2;
    localparam logic [3:0] S_MKP  = 4'd3;
    localparam logic [3:0] S_MKI  = 4'd4;
    localparam logic [3:0] S_MLO  = 4'd5;
    localparam logic [3:0] S_MHI  = 4'd6;
    localparam logic [3:0] S_MKD  = 4'd7;
    localparam logic [3:0] S_INT1 = 4'd8;
    localparam logic [3:0] S_INT2 = 4'd9;
    localparam logic [3:0] S_DIVI = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_DFIN = 4'd12;
    localparam logic [3:0] S_SUM  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0] r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic commit;

    assign o_s_tready = (r_state == S_IDLE);
    assign commit = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd.capture = 1'b0;
        o_cmd.op      = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) n_state = S_DEC;
            end
            S_DEC:  n_state = i_status.clear_req ? S_CLR : S_MKP;
            S_CLR: begin
                o_cmd.op = OP_CLR;
                n_state  = S_IDLE;
            end
            S_MKP: begin
                o_cmd.op = OP_MKP;
                n_state  = S_MKI;
            end
            S_MKI: begin
                o_cmd.op = OP_MKI;
                n_state  = S_MLO;
            end
            S_MLO: begin
                o_cmd.op = OP_MLO;
                n_state  = S_MHI;
            end
            S_MHI: begin
                o_cmd.op = OP_MHI;
                n_state  = S_MKD;
            end
            S_MKD: begin
                o_cmd.op = OP_MKD;
                n_state  = S_INT1;
            end
            S_INT1: begin
                o_cmd.op = OP_INT1;
                n_state  = S_INT2;
            end
            S_INT2: begin
                o_cmd.op = OP_INT2;
                n_state  = S_DIVI;
            end
            S_DIVI: begin
                // zero quotient stands for a disabled derivative
                o_cmd.op = OP_DIVI;
                n_cnt    = CNT_W'(DIV_STEPS - 1);
                n_state  = i_status.d_enable ? S_DIV : S_DFIN;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_DFIN;
            end
            S_DFIN: begin
                o_cmd.op = OP_DFIN;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (commit) begin
                    o_cmd.op = OP_COMMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit)                  n_out_valid = 1'b1;
        else if (i_m_tready)         n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared outside the output step");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_tready) |=> (r_state == S_OUT))
        else $error("result overwritten while stalled");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(DIV_STEPS - 1)))
        else $error("divider count out of range");

endmodule

`default_nettype wire

// File: rtl/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Fixed-point PID controller with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// Datapath: an update item runs through one shared multiplier over five
//   products and a divider at two quotient bits per cycle, whose iteration
//   steps are skipped without a derivative.
// Throughput: one item at a time; the next is taken once the result sits in
//   the output register, and a result held by the sink stalls the next commit.
// Reset: synchronous, active low; clears integral, history and gains to defaults.
`default_nettype none

module pid_controller_antiwindup import pidaw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration writes
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [63:0]       i_s_tdata,   // [31:0] error_value, [63:32] time_step
    input  wire logic [0:0]        i_s_tuser,   // [0] action
    // result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [31:0]            o_m_tdata,   // [31:0] drive_value
    output logic [1:0]             o_m_tuser    // [1:0] clamp_state
);

    t_cmd    cmd;
    t_status status;

    // sequencer: handshakes and step order
    pidaw_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic, gains and controller state
    pidaw_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_action    (i_s_tuser[0]),
        .i_error     (i_s_tdata[31:0]),
        .i_dt        (i_s_tdata[63:32]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_drive     (o_m_tdata),
        .o_clamp     (o_m_tuser)
    );

endmodule

`default_nettype wire
